/* design/sbf_pkg.sv */
// Shared types and constants for the stereo biquad filterbank.
// Used by sbf_mac and stereo_biquad_filterbank_top; depends on nothing else.
package sbf_pkg;

   // Sizing of the filterbank.
   localparam int BANDS       = 8;
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 32;
   localparam int HIST_BITS   = 32;
   localparam int COEF_FRAC   = COEF_BITS - 4;
   localparam int GAIN_FRAC   = COEF_BITS - 5;

   // Biquads are numbered band*2 + stage; five coefficients and four history words each.
   localparam int NQ        = 2 * BANDS;
   localparam int QW        = $clog2(NQ);
   localparam int NCOEF     = NQ * 5;
   localparam int CADDR_W   = $clog2(NCOEF);
   localparam int HADDR_W   = QW + 3;
   localparam int BW        = (BANDS > 1) ? $clog2(BANDS) : 1;

   // Datapath widths.
   localparam int PROD_W  = COEF_BITS + HIST_BITS;
   localparam int ACC_W   = PROD_W + 3;
   localparam int GTERM_W = PROD_W + 1 - GAIN_FRAC;
   localparam int SUM_W   = GTERM_W + $clog2(BANDS) + 1;

   // Action codes.
   localparam logic [1:0] ACT_PROCESS = 2'd0;
   localparam logic [1:0] ACT_COEF    = 2'd1;
   localparam logic [1:0] ACT_GAIN    = 2'd2;

   // Coefficient indexes within a biquad.
   localparam logic [2:0] K_B0   = 3'd0;
   localparam logic [2:0] K_B1   = 3'd1;
   localparam logic [2:0] K_A1   = 3'd3;
   localparam logic [2:0] K_LAST = 3'd4;

   typedef struct packed {
      logic [1:0]                    action;
      logic signed [SAMPLE_BITS-1:0] sample_left;
      logic signed [SAMPLE_BITS-1:0] sample_right;
      logic [2:0]                    band;
      logic                          filter_select;
      logic [2:0]                    coef_index;
      logic signed [31:0]            coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
      logic                          clipped;
   } rsp_type;

   // Controls for the shared multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic accum;
      logic sub;
   } mac_ctrl_type;

endpackage

/* design/sbf_mac.sv */
// Shared multiply-accumulate unit: registered product, accumulator, rounding.
// Depends on sbf_pkg.
module sbf_mac import sbf_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  mac_ctrl_type                ctrl,
   input  logic signed [COEF_BITS-1:0] op_a,
   input  logic signed [HIST_BITS-1:0] op_b,
   output logic signed [HIST_BITS-1:0] y_sat,
   output logic signed [GTERM_W-1:0]   gain_term
);

   localparam logic signed [ACC_W-1:0]  HALF_C = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [PROD_W:0]   HALF_G = (PROD_W + 1)'(1) << (GAIN_FRAC - 1);
   localparam logic signed [ACC_W-1:0]  Y_MAX  = ACC_W'((64'd1 << (HIST_BITS - 1)) - 64'd1);
   localparam logic signed [ACC_W-1:0]  Y_MIN  = -Y_MAX - ACC_W'(1);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     v_ff;
   logic                     sub_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [ACC_W-1:0]  shifted;
   logic signed [PROD_W:0]   grnd;

   // The product is registered every cycle; the accumulate flag follows it.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (reset) begin
         v_ff   <= 1'b0;
         sub_ff <= 1'b0;
      end else begin
         v_ff   <= ctrl.accum;
         sub_ff <= ctrl.sub;
      end
   end

   // The five biquad products are summed exactly.
   assign prod_ext = ACC_W'(prod_ff);
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (v_ff) begin
         acc_ff <= sub_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
      end
   end

   // Round half up, then saturate to the history word.
   always_comb begin
      rnd     = acc_ff + HALF_C;
      shifted = rnd >>> COEF_FRAC;
      if (shifted > Y_MAX) begin
         y_sat = Y_MAX[HIST_BITS-1:0];
      end else if (shifted < Y_MIN) begin
         y_sat = Y_MIN[HIST_BITS-1:0];
      end else begin
         y_sat = shifted[HIST_BITS-1:0];
      end
   end

   // Gain product rounded the same way, taken straight from the product register.
   always_comb begin
      grnd      = (PROD_W + 1)'(prod_ff) + HALF_G;
      gain_term = GTERM_W'(grnd >>> GAIN_FRAC);
   end

endmodule

/* design/stereo_biquad_filterbank_top.sv */
// Top level of the stereo eight-band biquad filterbank.
// Depends on sbf_pkg and sbf_mac.
//
// Requests arrive on the req_ channel (valid/ready). A process request carries a stereo
// frame and yields exactly one transfer on the rsp_ channel; coefficient and gain writes
// yield nothing. Writing a coefficient clears that biquad's history in both channels.
// A frame runs as 32 jobs (16 biquads times two channels) on one shared multiplier.
// Each job reads coefficients and history and multiply-accumulates, rounds, and writes
// the history back; lowpass jobs then scale by the band gain and add to the channel sum.
// After the last job the result register is loaded. The one-read-port memories and the
// single multiplier make the jobs run one after another.
// Reset takes effect at once: coefficients read as b0 = 1.0 and all history as zero,
// through per-entry coefficient and per-biquad history valid bits; gains reset to 1.0.
// No clearing pass is needed.
// The result sits in an output register. When the receiver stalls, the next request is
// still taken, and the block only waits when a newer result is ready to load.
module stereo_biquad_filterbank_top import sbf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC, ST_ROUND, ST_WB, ST_GMUL, ST_GACC, ST_DONE
   } state_type;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;
   localparam logic signed [COEF_BITS-1:0] GAIN_ONE = COEF_BITS'(1) << GAIN_FRAC;
   localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [SUM_W-1:0] S_MIN = -S_MAX - SUM_W'(1);

   state_type state_ff;
   logic [2:0]    cnt_ff;
   logic [QW-1:0] q_ff;
   logic          ch_ff;
   logic signed [SAMPLE_BITS-1:0] xl_ff, xr_ff;
   logic signed [HIST_BITS-1:0]   stage_ff [2];
   logic signed [HIST_BITS-1:0]   y_ff, h0_ff, h2_ff;
   logic signed [SUM_W-1:0]       sum_ff [2];
   logic signed [COEF_BITS-1:0]   gain_ff [BANDS];
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   // Memories and their valid bits.
   logic signed [COEF_BITS-1:0] coef_mem [NCOEF];
   logic signed [HIST_BITS-1:0] hist_mem [2*NQ*4];
   logic [NCOEF-1:0]            coef_vld_ff;
   logic [2*NQ-1:0]             hist_vld_ff;
   logic signed [COEF_BITS-1:0] coef_rd_ff;
   logic signed [HIST_BITS-1:0] hist_rd_ff;
   logic          coef_rd_vld_ff, hist_rd_vld_ff;
   logic          iss_ff;
   logic [2:0]    k1_ff;

   logic          req_fire, rsp_fire, load_rsp;
   logic          wr_coef, wr_gain;
   logic [QW-1:0] wr_q;
   logic [CADDR_W-1:0] wr_caddr, rd_caddr;
   logic [HADDR_W-1:0] rd_haddr, wr_haddr;
   logic          issue;
   logic          hist_we;
   logic signed [HIST_BITS-1:0] hist_wdata;
   logic signed [HIST_BITS-1:0] x_op;
   logic signed [COEF_BITS-1:0] coef_eff;
   logic signed [HIST_BITS-1:0] hist_eff;
   logic signed [COEF_BITS-1:0] mul_a;
   logic signed [HIST_BITS-1:0] mul_b;
   mac_ctrl_type mac_ctrl;
   logic signed [HIST_BITS-1:0] y_sat;
   logic signed [GTERM_W-1:0]   gain_term;
   logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;
   logic          clip_l, clip_r;

   // Handshakes.
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Write requests, decoded at acceptance.
   assign wr_q     = QW'({req_data.band, req_data.filter_select});
   assign wr_coef  = req_fire && (req_data.action == ACT_COEF)
                     && (int'(req_data.band) < BANDS) && (req_data.coef_index <= K_LAST);
   assign wr_gain  = req_fire && (req_data.action == ACT_GAIN)
                     && (int'(req_data.band) < BANDS);
   assign wr_caddr = CADDR_W'(wr_q) * CADDR_W'(5) + CADDR_W'(req_data.coef_index);

   // Read addresses for the current multiply-accumulate step.
   assign issue    = (state_ff == ST_MAC) && (cnt_ff <= K_LAST);
   assign rd_caddr = CADDR_W'(q_ff) * CADDR_W'(5) + CADDR_W'(cnt_ff);
   assign rd_haddr = {ch_ff, q_ff, 2'(cnt_ff - K_B1)};
   assign wr_haddr = {ch_ff, q_ff, cnt_ff[1:0]};

   // Coefficient memory: written by requests, read during jobs.
   always_ff @(posedge clock) begin
      if (wr_coef) begin
         coef_mem[wr_caddr] <= COEF_BITS'(req_data.coef_value);
      end
      coef_rd_ff <= coef_mem[rd_caddr];
   end

   // History memory, left channel in the lower half.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[wr_haddr] <= hist_wdata;
      end
      hist_rd_ff <= hist_mem[rd_haddr];
   end

   // Read pipeline tags and valid bits of the memories.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         hist_vld_ff <= '0;
         iss_ff      <= 1'b0;
      end else begin
         iss_ff <= issue;
         if (wr_coef) begin
            coef_vld_ff[wr_caddr]     <= 1'b1;
            hist_vld_ff[{1'b0, wr_q}] <= 1'b0;
            hist_vld_ff[{1'b1, wr_q}] <= 1'b0;
         end
         if (state_ff == ST_WB && cnt_ff == 3'd3) begin
            hist_vld_ff[{ch_ff, q_ff}] <= 1'b1;
         end
      end
      k1_ff          <= cnt_ff;
      coef_rd_vld_ff <= coef_vld_ff[rd_caddr];
      hist_rd_vld_ff <= hist_vld_ff[{ch_ff, q_ff}];
   end

   // Unwritten entries read as their reset values.
   always_comb begin
      if (coef_rd_vld_ff) begin
         coef_eff = coef_rd_ff;
      end else begin
         coef_eff = (k1_ff == K_B0) ? COEF_ONE : '0;
      end
      hist_eff = hist_rd_vld_ff ? hist_rd_ff : '0;
   end

   // Stage input: the frame sample for highpass, the highpass output for lowpass.
   always_comb begin
      if (!q_ff[0]) begin
         x_op = ch_ff ? HIST_BITS'(xr_ff) : HIST_BITS'(xl_ff);
      end else begin
         x_op = stage_ff[ch_ff];
      end
   end

   // Multiplier operands and accumulate control.
   always_comb begin
      mac_ctrl.clear = (state_ff == ST_IDLE) || (state_ff == ST_ROUND);
      mac_ctrl.accum = iss_ff;
      mac_ctrl.sub   = (k1_ff >= K_A1);
      if (state_ff == ST_GMUL) begin
         mul_a = gain_ff[BW'(q_ff >> 1)];
         mul_b = y_ff;
      end else begin
         mul_a = coef_eff;
         mul_b = (k1_ff == K_B0) ? x_op : hist_eff;
      end
   end

   sbf_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .op_a      (mul_a),
      .op_b      (mul_b),
      .y_sat     (y_sat),
      .gain_term (gain_term)
   );

   // History write-back: x1 = x, x2 = old x1, y1 = y, y2 = old y1.
   always_comb begin
      hist_we = (state_ff == ST_WB);
      case (cnt_ff[1:0])
         2'd0:    hist_wdata = x_op;
         2'd1:    hist_wdata = h0_ff;
         2'd2:    hist_wdata = y_ff;
         default: hist_wdata = h2_ff;
      endcase
   end

   // Output saturation of the band sums.
   always_comb begin
      clip_l = (sum_ff[0] > S_MAX) || (sum_ff[0] < S_MIN);
      clip_r = (sum_ff[1] > S_MAX) || (sum_ff[1] < S_MIN);
      if (sum_ff[0] > S_MAX)      sat_l = S_MAX[SAMPLE_BITS-1:0];
      else if (sum_ff[0] < S_MIN) sat_l = S_MIN[SAMPLE_BITS-1:0];
      else                        sat_l = sum_ff[0][SAMPLE_BITS-1:0];
      if (sum_ff[1] > S_MAX)      sat_r = S_MAX[SAMPLE_BITS-1:0];
      else if (sum_ff[1] < S_MIN) sat_r = S_MIN[SAMPLE_BITS-1:0];
      else                        sat_r = sum_ff[1][SAMPLE_BITS-1:0];
   end

   // Sequencer over biquads and channels, with the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         q_ff         <= '0;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BANDS; b++) begin
            gain_ff[b] <= GAIN_ONE;
         end
      end else begin
         if (rsp_fire && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_gain) begin
            gain_ff[BW'(req_data.band)] <= COEF_BITS'(req_data.coef_value);
         end
         // Capture old x1 and y1 as they come out of the history read.
         if (iss_ff && k1_ff == K_B1) begin
            h0_ff <= hist_eff;
         end
         if (iss_ff && k1_ff == K_A1) begin
            h2_ff <= hist_eff;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_data.action == ACT_PROCESS) begin
                  xl_ff     <= req_data.sample_left;
                  xr_ff     <= req_data.sample_right;
                  sum_ff[0] <= '0;
                  sum_ff[1] <= '0;
                  q_ff      <= '0;
                  ch_ff     <= 1'b0;
                  cnt_ff    <= '0;
                  state_ff  <= ST_MAC;
               end
            end
            ST_MAC: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               y_ff <= y_sat;
               if (!q_ff[0]) begin
                  stage_ff[ch_ff] <= y_sat;
               end
               cnt_ff   <= '0;
               state_ff <= ST_WB;
            end
            ST_WB: begin
               if (cnt_ff == 3'd3) begin
                  cnt_ff <= '0;
                  if (q_ff[0]) begin
                     state_ff <= ST_GMUL;
                  end else if (!ch_ff) begin
                     ch_ff    <= 1'b1;
                     state_ff <= ST_MAC;
                  end else begin
                     ch_ff    <= 1'b0;
                     q_ff     <= q_ff + QW'(1);
                     state_ff <= ST_MAC;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            ST_GMUL: begin
               state_ff <= ST_GACC;
            end
            ST_GACC: begin
               sum_ff[ch_ff] <= sum_ff[ch_ff] + SUM_W'(gain_term);
               cnt_ff        <= '0;
               if (!ch_ff) begin
                  ch_ff    <= 1'b1;
                  state_ff <= ST_MAC;
               end else if (q_ff == QW'(NQ - 1)) begin
                  ch_ff    <= 1'b0;
                  state_ff <= ST_DONE;
               end else begin
                  ch_ff    <= 1'b0;
                  q_ff     <= q_ff + QW'(1);
                  state_ff <= ST_MAC;
               end
            end
            ST_DONE: begin
               if (load_rsp) begin
                  rsp_ff.out_left  <= sat_l;
                  rsp_ff.out_right <= sat_r;
                  rsp_ff.clipped   <= clip_l || clip_r;
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the stereo biquad filterbank: directed and random transfers checked
// against a bit-exact predictor of the filter arithmetic. Depends on sbf_pkg and the RTL.
module tb_top;
   import sbf_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   stereo_biquad_filterbank_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Predictor state: coefficients, gains and per-biquad history for both channels.
   logic signed [31:0] coefs [NCOEF];
   logic signed [31:0] gains [BANDS];
   logic signed [31:0] hist_l [NQ*4];
   logic signed [31:0] hist_r [NQ*4];

   rsp_type frames_expected[$];
   int      error_count;
   int      cycle_count = 0;
   bit      calm;
   int      send_gap;

   // Clock, 20 ns period.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("[stereo_biquad_filterbank_top] ERROR");
         $finish;
      end
   end

   task automatic report(input string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // One direct-form-I stage; the wide exact sum is rounded half up by an arithmetic shift.
   function automatic logic signed [31:0] run_biquad(input int q, input bit right,
                                                      input logic signed [31:0] x);
      logic signed [127:0] acc;
      logic signed [31:0]  h0, h1, h2, h3, y;
      int                  c;
      c = q * 5;
      h0 = right ? hist_r[q*4]   : hist_l[q*4];
      h1 = right ? hist_r[q*4+1] : hist_l[q*4+1];
      h2 = right ? hist_r[q*4+2] : hist_l[q*4+2];
      h3 = right ? hist_r[q*4+3] : hist_l[q*4+3];
      acc = 128'(coefs[c]) * 128'(x) + 128'(coefs[c+1]) * 128'(h0)
          + 128'(coefs[c+2]) * 128'(h1) - 128'(coefs[c+3]) * 128'(h2)
          - 128'(coefs[c+4]) * 128'(h3);
      acc = (acc + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      y = sat32(acc);
      if (right) begin
         hist_r[q*4+1] = h0; hist_r[q*4] = x; hist_r[q*4+3] = h2; hist_r[q*4+2] = y;
      end else begin
         hist_l[q*4+1] = h0; hist_l[q*4] = x; hist_l[q*4+3] = h2; hist_l[q*4+2] = y;
      end
      return y;
   endfunction

   function automatic logic signed [127:0] bank_sum(input bit right,
                                                      input logic signed [31:0] x);
      logic signed [127:0] total, g;
      logic signed [31:0]  t;
      total = 0;
      for (int b = 0; b < BANDS; b++) begin
         t = run_biquad(2*b, right, x);
         t = run_biquad(2*b + 1, right, t);
         g = 128'(gains[b]) * 128'(t) + (128'sd1 <<< (GAIN_FRAC - 1));
         total += g >>> GAIN_FRAC;
      end
      return total;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(
         input logic signed [127:0] v, inout bit clip);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (SAMPLE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clip = 1'b1;
         return hi[SAMPLE_BITS-1:0];
      end
      if (v < lo) begin
         clip = 1'b1;
         return lo[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic void predict_reset();
      for (int i = 0; i < NCOEF; i++)
         coefs[i] = (i % 5 == 0) ? (32'sd1 <<< COEF_FRAC) : 32'sd0;
      for (int i = 0; i < BANDS; i++) gains[i] = 32'sd1 <<< GAIN_FRAC;
      for (int i = 0; i < NQ*4; i++) begin
         hist_l[i] = 0;
         hist_r[i] = 0;
      end
   endfunction

   // Updates the predictor for one accepted transfer and queues any frame result.
   function automatic void predict_request(input req_type r);
      rsp_type o;
      bit      clip;
      int      q;
      clip = 1'b0;
      case (r.action)
         ACT_PROCESS: begin
            o.out_left  = clip_sample(bank_sum(1'b0, 32'(r.sample_left)), clip);
            o.out_right = clip_sample(bank_sum(1'b1, 32'(r.sample_right)), clip);
            o.clipped   = clip;
            frames_expected.push_back(o);
         end
         ACT_COEF: begin
            if (r.band < BANDS && r.coef_index <= K_LAST) begin
               q = r.band * 2 + r.filter_select;
               coefs[q*5 + r.coef_index] = r.coef_value;
               for (int i = 0; i < 4; i++) begin
                  hist_l[q*4+i] = 0;
                  hist_r[q*4+i] = 0;
               end
            end
         end
         ACT_GAIN: begin
            if (r.band < BANDS) gains[r.band] = r.coef_value;
         end
         default: ;
      endcase
   endfunction

   // Sends one transfer after an optional random gap; valid stays high between
   // back-to-back transfers and drops only for a gap.
   task automatic send_request(input req_type r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         send_gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (send_gap) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_request(r);
      @(negedge clock);
   endtask

   // Receiver stalls in random bursts.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) rsp_ready <= 1'b1;
         else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else rsp_ready <= 1'b1;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_expected.size() == 0) report("result with none expected");
         else begin
            rsp_type e;
            e = frames_expected.pop_front();
            if (rsp_data.out_left !== e.out_left)
               report($sformatf("out_left %0d, expected %0d", rsp_data.out_left,
                                 e.out_left));
            if (rsp_data.out_right !== e.out_right)
               report($sformatf("out_right %0d, expected %0d", rsp_data.out_right,
                                 e.out_right));
            if (rsp_data.clipped !== e.clipped)
               report($sformatf("clipped %0b, expected %0b", rsp_data.clipped,
                                 e.clipped));
         end
      end
   end

   function automatic req_type frame(input logic [23:0] l, input logic [23:0] r);
      req_type q;
      q = '0;
      q.action = ACT_PROCESS;
      q.sample_left = l;
      q.sample_right = r;
      q.band = 3'($urandom);
      q.coef_index = 3'($urandom);
      q.filter_select = 1'($urandom);
      q.coef_value = $urandom;
      return q;
   endfunction

   function automatic req_type write(input logic [1:0] act, input logic [2:0] band,
                                     input bit sel, input logic [2:0] k,
                                     input logic [31:0] val);
      req_type q;
      q = '0;
      q.action = act;
      q.band = band;
      q.filter_select = sel;
      q.coef_index = k;
      q.coef_value = val;
      q.sample_left = 24'($urandom);
      q.sample_right = 24'($urandom);
      return q;
   endfunction

   function automatic logic [23:0] random_sample();
      case ($urandom_range(0, 4))
         0: return 24'h7fffff;
         1: return 24'h800000;
         2: return 24'($urandom);
         default: return 24'($signed(12'($urandom)));
      endcase
   endfunction

   // Extreme samples through the reset passthrough, where eight unity bands clip.
   task automatic test_reset_passthrough();
      send_request(frame(24'h7fffff, 24'h800000));
      send_request(frame(24'h000000, 24'h000001));
      send_request(frame(24'h800000, 24'h7fffff));
      send_request(frame(24'h0fffff, 24'hfff000));
   endtask

   // Every write case, ignored writes included, then frames through extreme settings.
   task automatic test_directed_writes();
      send_request(write(ACT_COEF, 3'd0, 1'b0, K_B1, 32'sh10000000));
      send_request(write(ACT_COEF, 3'd0, 1'b1, K_A1, 32'h80000000));
      send_request(write(ACT_COEF, 3'd1, 1'b0, 3'd7, 32'h7fffffff));
      send_request(write(ACT_COEF, 3'd1, 1'b0, 3'd5, 32'h7fffffff));
      send_request(write(ACT_GAIN, 3'd7, 1'b0, K_B0, 32'h7fffffff));
      send_request(write(ACT_GAIN, 3'd2, 1'b0, K_B0, 32'h80000000));
      send_request(write(2'd3, 3'd3, 1'b1, K_B0, 32'h0));
      send_request(frame(24'h7fffff, 24'h800000));
      send_request(frame(24'h123456, 24'h800000));
      send_request(write(ACT_COEF, 3'd7, 1'b1, K_LAST, 32'h7fffffff));
      send_request(write(ACT_COEF, 3'd7, 1'b1, 3'd2, 32'h80000000));
      send_request(frame(24'h7fffff, 24'h7fffff));
      send_request(frame(24'h000000, 24'h000000));
      send_request(write(2'd3, 3'd0, 1'b0, K_B0, 32'h0));
      send_request(frame(24'h400000, 24'hc00000));
   endtask

   // Random coefficient and gain set: small, mostly stable taps with occasional extremes.
   task automatic load_random_bank();
      logic [31:0] v;
      for (int q = 0; q < NQ; q++)
         for (int k = 0; k <= 4; k++) begin
            if ($urandom_range(0, 9) == 0) v = $urandom;
            else if (k == 0) v = 32'($signed(28'($urandom)) >>> 1);
            else v = 32'($signed(24'($urandom)));
            if ($urandom_range(0, 2) != 0)
               send_request(write(ACT_COEF, 3'(q / 2), 1'(q % 2), 3'(k), v));
         end
      for (int b = 0; b < BANDS; b++) begin
         v = ($urandom_range(0, 7) == 0) ? $urandom : 32'($signed(27'($urandom)) >>> 2);
         send_request(write(ACT_GAIN, 3'(b), 1'b0, K_B0, v));
      end
   endtask

   // Mostly frames over random banks, with scattered writes and noise.
   task automatic test_random_traffic(input int count);
      req_type r;
      for (int n = 0; n < count; n++) begin
         if (n % 300 == 0) load_random_bank();
         case ($urandom_range(0, 19))
            0: r = write(ACT_COEF, 3'($urandom), 1'($urandom), 3'($urandom), $urandom);
            1: r = write(ACT_GAIN, 3'($urandom), 1'($urandom), 3'($urandom), $urandom);
            2: r = write(2'd3, 3'($urandom), 1'($urandom), 3'($urandom), $urandom);
            default: r = frame(random_sample(), random_sample());
         endcase
         send_request(r);
      end
   endtask

   initial begin
      error_count = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      predict_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_passthrough();
      test_directed_writes();
      test_random_traffic(1000);
      calm = 1'b1;
      test_random_traffic(400);
      req_valid <= 1'b0;
      while (frames_expected.size() != 0 && cycle_count < 3000000) @(posedge clock);
      repeat (600) @(posedge clock);
      if (error_count == 0) $display("[stereo_biquad_filterbank_top] OK");
      else $display("[stereo_biquad_filterbank_top] ERROR");
      $finish;
   end
endmodule

/* sim.f */
design/sbf_pkg.sv
design/sbf_mac.sv
design/stereo_biquad_filterbank_top.sv
test/tb_top.sv
